// File: rtl/iir_biquad_transposed_df2_macros.svh
// Assertion macros shared by the biquad filter modules.
`ifndef IIR_BIQUAD_TRANSPOSED_DF2_MACROS_SVH
`define IIR_BIQUAD_TRANSPOSED_DF2_MACROS_SVH

`ifndef SYNTHESIS
`define IBQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define IBQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`else
`define IBQ_ASSERT(lbl, prop, msg)
`define IBQ_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/ibq_pkg.sv
// Package with constants, codes and control types of the biquad filter.
`timescale 1ns / 1ps
package ibq_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEF_WIDTH_DEF   = 18;
  localparam int COEF_INT_BITS    = 4;
  localparam int STATE_BITS       = 40;
  localparam int CFG_IDX_W        = 3;
  localparam int B0_RESET         = 16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FEED_B0 = 3'd0,
    CFG_FEED_B1 = 3'd1,
    CFG_FEED_B2 = 3'd2,
    CFG_BACK_A1 = 3'd3,
    CFG_BACK_A2 = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_Y,
    ST_B1,
    ST_A1,
    ST_B2,
    ST_A2,
    ST_HOLD
  } state_e;

  typedef enum logic [2:0] {
    MUL_B0X,
    MUL_B1X,
    MUL_A1Y,
    MUL_B2X,
    MUL_A2Y
  } mul_op_e;

  typedef struct packed {
    logic    load_x;
    logic    use_in;
    mul_op_e mul_op;
    logic    clr_state;
    logic    load_y;
    logic    load_sum;
    logic    load_s0;
    logic    load_prod;
    logic    load_s1;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// File: rtl/ibq_if.sv
// Valid/ready channel interfaces for the filter's sample input and result output.
`timescale 1ns / 1ps
interface ibq_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output kind, output sample_in, input ready);
  modport sink   (input valid, input kind, input sample_in, output ready);
endinterface

interface ibq_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// File: rtl/ibq_ctrl.sv
// Sequencer that steps one sample through the shared multiplier schedule.
`timescale 1ns / 1ps
`include "iir_biquad_transposed_df2_macros.svh"
module ibq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_kind_i,
  output logic            in_ready_o,
  input  ibq_pkg::status_t status_i,
  output ibq_pkg::cmd_t    cmd_o
);
  import ibq_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && !in_kind_i) state_d = ST_Y;
      end
      ST_Y:  state_d = ST_B1;
      ST_B1: state_d = ST_A1;
      ST_A1: state_d = ST_B2;
      ST_B2: state_d = ST_A2;
      ST_A2: begin
        state_d = status_i.out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.mul_op = MUL_B0X;
    case (state_q)
      ST_IDLE: begin
        // The first product is taken straight from the input beat.
        cmd_o.use_in    = 1'b1;
        cmd_o.load_x    = accept && !in_kind_i;
        cmd_o.clr_state = accept && in_kind_i;
      end
      ST_Y: begin
        cmd_o.load_y = 1'b1;
        cmd_o.mul_op = MUL_B1X;
      end
      ST_B1: begin
        cmd_o.load_sum = 1'b1;
        cmd_o.mul_op   = MUL_A1Y;
      end
      ST_A1: begin
        cmd_o.load_s0 = 1'b1;
        cmd_o.mul_op  = MUL_B2X;
      end
      ST_B2: begin
        cmd_o.load_prod = 1'b1;
        cmd_o.mul_op    = MUL_A2Y;
      end
      ST_A2: begin
        cmd_o.load_s1  = 1'b1;
        cmd_o.out_load = status_i.out_free;
      end
      ST_HOLD: begin
        cmd_o.out_load = status_i.out_free;
      end
      default: begin
        cmd_o.use_in = 1'b0;
      end
    endcase
  end

  `IBQ_ASSERT(a_sample_starts, (accept && !in_kind_i) |=> (state_q == ST_Y), "sample did not start")
  `IBQ_ASSERT_IMP(a_load_when_free, cmd_o.out_load, status_i.out_free, "result loaded over a full slot")
  `IBQ_ASSERT(a_hold_on_stall, (state_q == ST_A2 && !status_i.out_free) |=> (state_q == ST_HOLD), "stalled result not held")

endmodule

// File: rtl/ibq_datapath.sv
// Coefficient registers, shared multiplier, state words and result register.
`timescale 1ns / 1ps
`include "iir_biquad_transposed_df2_macros.svh"
module ibq_datapath #(
  parameter int SAMPLE_WIDTH = ibq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = ibq_pkg::COEF_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ibq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [COEF_WIDTH-1:0]          cfg_data_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_i,
  input  ibq_pkg::cmd_t                  cmd_i,
  output ibq_pkg::status_t               status_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample_o
);
  import ibq_pkg::*;

  localparam int FRAC = COEF_WIDTH - COEF_INT_BITS;
  localparam int PW   = COEF_WIDTH + SAMPLE_WIDTH;
  localparam int RW   = STATE_BITS + 1;
  localparam logic [COEF_WIDTH-1:0] B0_RST = COEF_WIDTH'(B0_RESET);
  localparam logic signed [RW-1:0] HALF = RW'(64'(1) << (FRAC - 1));
  localparam logic signed [RW-1:0] YMAX = RW'((64'(1) << (SAMPLE_WIDTH - 1)) - 64'(1));
  localparam logic signed [RW-1:0] YMIN = ~YMAX;

  logic signed [COEF_WIDTH-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;
  logic signed [SAMPLE_WIDTH-1:0] x_q, y_q, y_d, out_q;
  logic signed [STATE_BITS-1:0]   s0_q, s1_q, t_q, prod_q, acc;
  logic signed [COEF_WIDTH-1:0]   coef_op;
  logic signed [SAMPLE_WIDTH-1:0] samp_op;
  logic signed [PW-1:0]           mul_full;
  logic signed [RW-1:0]           rnd_sum, rnd_val;
  logic                           out_valid_q;
  logic                           out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= B0_RST;
      b1_q <= '0;
      b2_q <= '0;
      a1_q <= '0;
      a2_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FEED_B0: b0_q <= cfg_data_i;
        CFG_FEED_B1: b1_q <= cfg_data_i;
        CFG_FEED_B2: b2_q <= cfg_data_i;
        CFG_BACK_A1: a1_q <= cfg_data_i;
        CFG_BACK_A2: a2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd_i.mul_op)
      MUL_B0X: coef_op = b0_q;
      MUL_B1X: coef_op = b1_q;
      MUL_A1Y: coef_op = a1_q;
      MUL_B2X: coef_op = b2_q;
      MUL_A2Y: coef_op = a2_q;
      default: coef_op = b0_q;
    endcase
  end

  always_comb begin
    if (cmd_i.use_in) begin
      samp_op = in_sample_i;
    end else if (cmd_i.mul_op == MUL_A1Y || cmd_i.mul_op == MUL_A2Y) begin
      samp_op = y_q;
    end else begin
      samp_op = x_q;
    end
  end

  assign mul_full = coef_op * samp_op;

  // Output word: round half up at the state fraction point, then clamp.
  assign acc     = s0_q + prod_q;
  assign rnd_sum = RW'(acc) + HALF;
  assign rnd_val = rnd_sum >>> FRAC;

  always_comb begin
    if (rnd_val > YMAX) begin
      y_d = SAMPLE_WIDTH'(YMAX);
    end else if (rnd_val < YMIN) begin
      y_d = SAMPLE_WIDTH'(YMIN);
    end else begin
      y_d = SAMPLE_WIDTH'(rnd_val);
    end
  end

  // Products land in state units directly and are resized to the state width.
  always_ff @(posedge clk_i) begin
    prod_q <= STATE_BITS'(mul_full);
    if (cmd_i.load_x) x_q <= in_sample_i;
    if (cmd_i.load_y) y_q <= y_d;
    if (cmd_i.load_sum) begin
      t_q <= s1_q + prod_q;
    end else if (cmd_i.load_prod) begin
      t_q <= prod_q;
    end
    if (cmd_i.out_load) out_q <= y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0;
      s1_q <= '0;
    end else if (cmd_i.clr_state) begin
      s0_q <= '0;
      s1_q <= '0;
    end else begin
      if (cmd_i.load_s0) s0_q <= t_q - prod_q;
      if (cmd_i.load_s1) s1_q <= t_q - prod_q;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = out_free;
  assign out_valid_o       = out_valid_q;
  assign out_sample_o      = out_q;

  `IBQ_ASSERT(a_load_sets_valid, cmd_i.out_load |=> out_valid_q, "loaded result not valid")
  `IBQ_ASSERT(a_clear_zeroes, cmd_i.clr_state |=> (s0_q == '0 && s1_q == '0), "clear left state")
  `IBQ_ASSERT_IMP(a_clear_alone, cmd_i.clr_state, !(cmd_i.load_y || cmd_i.out_load || cmd_i.load_x), "clear overlaps a sample")

endmodule

// File: rtl/iir_biquad_transposed_df2.sv
// Top level of the second-order transposed direct form II IIR filter.
//
// Input channel in_ch carries one beat per item: kind 0 filters sample_in,
// kind 1 zeroes both state words and yields no result. Output channel
// out_ch carries one beat with sample_out for every filtered sample.
// Coefficients b0, b1, b2, a1, a2 (already normalized, Q3.14 at the default
// width) are written through cfg_we_i / cfg_idx_i / cfg_data_i. The user must
// write them only while idle; the block itself does not enforce this. From
// the accept cycle, which forms b0*x, a sample runs through five steps that
// share the single multiplier for y, b1*x, a1*y, b2*x and a2*y. The result
// is valid when the sequencer returns to idle, and the next sample may be
// accepted in that same cycle. A clear beat does not enter the schedule.
// The result sits in an output register; if the receiver stalls, one result
// waits there while the next sample is computed, and the block then holds
// that next result until the register frees. Reset clears the state words,
// sets b0 to 1.0 and the other coefficients to zero, and empties the
// output register.
`timescale 1ns / 1ps
module iir_biquad_transposed_df2 #(
  parameter int SAMPLE_WIDTH = ibq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = ibq_pkg::COEF_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ibq_in_if.sink                        in_ch,
  ibq_out_if.source                     out_ch,
  input  logic                          cfg_we_i,
  input  logic [ibq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COEF_WIDTH-1:0]         cfg_data_i
);
  import ibq_pkg::*;

  cmd_t    cmd;
  status_t status;

  ibq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_kind_i  (in_ch.kind),
    .in_ready_o (in_ch.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ibq_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_sample_i  (in_ch.sample_in),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (out_ch.ready),
    .out_valid_o  (out_ch.valid),
    .out_sample_o (out_ch.sample_out)
  );

endmodule
